@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker module sms_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, clocked on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Same-cycle implication, clocked on clk, off during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/sms_pkg.sv @@
`default_nettype none
package sms_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 32;
	localparam int KEY_W        = 32;
	localparam int OP_W         = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	localparam logic ST_DONE   = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/sms_cell.sv @@
`default_nettype none
module sms_cell
	import sms_pkg::*;
#(
	parameter int SW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          capture,
	input  logic [SW-1:0] cmp_key,
	input  logic [SW-1:0] ins_key,
	input  logic [SW-1:0] nb_key,
	input  logic          nb_valid,
	input  logic          prev_valid,
	input  logic          pfx,
	input  cell_ctl_t     ctl,
	output logic [SW-1:0] key_q,
	output logic          valid_q,
	output logic          hit_q
);

	logic take_ins;
	logic take_nb;

	// first free slot takes the new key; slots at and above the hit pull from the right
	assign take_ins = ctl.insert && !valid_q && prev_valid;
	assign take_nb  = ctl.remove && valid_q && pfx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (capture) begin
				hit_q <= valid_q && (key_q == cmp_key);
			end
			if (take_ins) begin
				valid_q <= 1'b1;
			end else if (take_nb) begin
				valid_q <= nb_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_ins) begin
			key_q <= ins_key;
		end else if (take_nb) begin
			key_q <= nb_key;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/sms_prefix.sv @@
`default_nettype none
module sms_prefix #(
	parameter int N = 64
) (
	input  logic [N-1:0] hit,
	output logic [N-1:0] pfx
);

	localparam int LV = (N > 1) ? $clog2(N) : 1;

	logic [N-1:0] lvl [LV+1];

	assign lvl[0] = hit;

	// log-depth inclusive OR scan
	for (genvar l = 0; l < LV; l++) begin : g_lvl
		for (genvar i = 0; i < N; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1 << l)];
			end else begin : g_pass
				assign lvl[l+1][i] = lvl[l][i];
			end
		end
	end

	assign pfx = lvl[LV];

endmodule
`default_nettype wire

@@ hw/rtl/set_membership_table.sv @@
`default_nettype none
// channel   | handshake        | payload
// ----------+------------------+--------------------------------------------------
// command   | start, busy      | operation, key
// result    | done (strobe)    | was_member, element_count, set_full, set_empty,
//           |                  | status
//
// In a transaction, the accept edge registers every cell's key compare; while busy is high,
// the clock edge applies the insert/shift across the cell row and registers the result.
// The result is on the ports during the cycle after that, marked by done; busy is low
// then, so the next command is taken in that same cycle.
// arst_n clears the fill count, the cell valid bits and the handshake state.
// The receiver cannot stall; done is a single-cycle strobe.
module set_membership_table
	import sms_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [OP_W-1:0]                   operation,
	input  logic signed [KEY_W-1:0]           key,
	output logic                              done,
	output logic                              was_member,
	output logic [$clog2(CAPACITY+1)-1:0]     element_count,
	output logic                              set_full,
	output logic                              set_empty,
	output logic                              status
);

	localparam int SW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int CNT_W = $clog2(CAPACITY+1);

	logic              busy_q;
	logic              done_q;
	logic [OP_W-1:0]   op_s1;
	logic [SW-1:0]     key_s1;
	logic [CNT_W-1:0]  count_q;
	logic              was_member_q;
	logic              status_q;

	logic              capture;
	logic [SW-1:0]     cmp_key;
	logic [CAPACITY-1:0] hit;
	logic [CAPACITY-1:0] valid;
	logic [CAPACITY-1:0] pfx;
	logic [SW-1:0]     cell_key [CAPACITY];
	logic              member;
	logic              full;
	logic              do_ins;
	logic              do_del;
	logic              reject;
	cell_ctl_t         ctl;

	assign capture = start && !busy_q;
	assign cmp_key = key[SW-1:0];
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign member  = pfx[CAPACITY-1];

	assign do_ins  = busy_q && (op_s1 == OP_INSERT) && !member && !full;
	assign reject  = (op_s1 == OP_INSERT) && !member && full;
	assign do_del  = busy_q && (op_s1 == OP_DELETE) && member;

	assign ctl.insert = do_ins;
	assign ctl.remove = do_del;

	sms_prefix #(.N(CAPACITY)) u_prefix (
		.hit (hit),
		.pfx (pfx)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [SW-1:0] nb_key;
		logic          nb_valid;
		logic          prev_valid;

		if (i == CAPACITY-1) begin : g_last
			assign nb_key   = '0;
			assign nb_valid = 1'b0;
		end else begin : g_mid
			assign nb_key   = cell_key[i+1];
			assign nb_valid = valid[i+1];
		end

		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_rest
			assign prev_valid = valid[i-1];
		end

		sms_cell #(.SW(SW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.capture    (capture),
			.cmp_key    (cmp_key),
			.ins_key    (key_s1),
			.nb_key     (nb_key),
			.nb_valid   (nb_valid),
			.prev_valid (prev_valid),
			.pfx        (pfx[i]),
			.ctl        (ctl),
			.key_q      (cell_key[i]),
			.valid_q    (valid[i]),
			.hit_q      (hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			busy_q <= capture;
			done_q <= busy_q;
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_del) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			op_s1  <= operation;
			key_s1 <= cmp_key;
		end
		if (busy_q) begin
			was_member_q <= member;
			status_q     <= (busy_q && reject) ? ST_REJECT : ST_DONE;
		end
	end

	assign busy          = busy_q;
	assign done          = done_q;
	assign was_member    = was_member_q;
	assign element_count = count_q;
	assign set_full      = full;
	assign set_empty     = (count_q == '0);
	assign status        = status_q;

endmodule
`default_nettype wire

@@ hw/rtl/sms_chk.sv @@
`default_nettype none
`include "assert_macros.svh"
module sms_chk #(
	parameter int CAPACITY = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire                          busy,
	input  wire                          done,
	input  wire                          was_member,
	input  wire [$clog2(CAPACITY+1)-1:0] element_count,
	input  wire                          set_full,
	input  wire                          set_empty,
	input  wire                          status
);

	`ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`ASSERT_NEXT(a_busy_done, busy, done && !busy, "result did not follow the busy cycle")
	`ASSERT_SAME(a_reject_full, done && status, set_full && !was_member, "reject without full set")
	`ASSERT_SAME(a_count_range, done, (element_count <= CAPACITY) && !(set_full && set_empty), "count out of range")

endmodule

bind set_membership_table sms_chk #(.CAPACITY(CAPACITY)) u_sms_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.was_member    (was_member),
	.element_count (element_count),
	.set_full      (set_full),
	.set_empty     (set_empty),
	.status        (status)
);
`default_nettype wire

@@ test/testbench.sv @@
module testbench;
	import sms_pkg::*;

	localparam int SLOTS = CAPACITY_DEF;
	localparam int POOL = 96;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic       was_member;
		logic [6:0] count;
		logic       full;
		logic       empty;
		logic       status;
	} set_reply_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [OP_W-1:0]         operation;
	logic signed [KEY_W-1:0] key;
	logic                    done;
	logic                    was_member;
	logic [6:0]              element_count;
	logic                    set_full;
	logic                    set_empty;
	logic                    status;

	logic [KEY_W-1:0] held_keys[SLOTS];
	int               held_count;
	set_reply_t       pending_replies[$];
	set_reply_t       oldest;
	logic [KEY_W-1:0] key_pool[POOL];
	int               errors;
	int               n_replies;
	int               n_rejects;
	int               n_removed;
	int               n_full_seen;
	int               n_empty_seen;
	bit               gaps_on;

	set_membership_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.key          (key),
		.done         (done),
		.was_member   (was_member),
		.element_count(element_count),
		.set_full     (set_full),
		.set_empty    (set_empty),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 600000);
		$display("tb: failure");
		$finish;
	end

	// Mirror of the set: compute the reply for one accepted transaction.
	task automatic apply_set_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
		int         pos;
		set_reply_t r;
		pos = held_count;
		for (int i = 0; i < held_count; i++)
			if (held_keys[i] == k && pos == held_count)
				pos = i;
		r.was_member = pos < held_count;
		r.status = ST_DONE;
		case (op)
			OP_INSERT: begin
				if (!r.was_member) begin
					if (held_count >= SLOTS) begin
						r.status = ST_REJECT;
						n_rejects++;
					end else begin
						held_keys[held_count] = k;
						held_count++;
					end
				end
			end
			OP_DELETE: begin
				if (r.was_member) begin
					for (int i = pos + 1; i < held_count; i++)
						held_keys[i-1] = held_keys[i];
					held_count--;
					n_removed++;
				end
			end
			default: ;
		endcase
		r.count = held_count[6:0];
		r.full = held_count == SLOTS;
		r.empty = held_count == 0;
		pending_replies.push_back(r);
	endtask

	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		key <= k;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_set_op(op, k);
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic paced_send(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
		if (gaps_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 13)) @(negedge clk);
		send_cmd(op, k);
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return $urandom;
		if (r < 45 && held_count > 0)
			return held_keys[$urandom_range(0, held_count - 1)];
		return key_pool[$urandom_range(0, POOL - 1)];
	endfunction

	function automatic logic [OP_W-1:0] pick_op(input int ins_pct, input int del_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			return OP_INSERT;
		if (r < ins_pct + del_pct)
			return OP_DELETE;
		if ($urandom_range(0, 19) == 0)
			return OP_SPARE;
		return OP_QUERY;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
			end else begin
				oldest = pending_replies.pop_front();
				n_replies++;
				if (oldest.full)
					n_full_seen++;
				if (oldest.empty)
					n_empty_seen++;
				if (was_member !== oldest.was_member) begin
					$error("was_member: expected %0d, got %0d", oldest.was_member, was_member);
					errors++;
				end
				if (element_count !== oldest.count) begin
					$error("element_count: expected %0d, got %0d", oldest.count, element_count);
					errors++;
				end
				if (set_full !== oldest.full) begin
					$error("set_full: expected %0d, got %0d", oldest.full, set_full);
					errors++;
				end
				if (set_empty !== oldest.empty) begin
					$error("set_empty: expected %0d, got %0d", oldest.empty, set_empty);
					errors++;
				end
				if (status !== oldest.status) begin
					$error("status: expected %0d, got %0d", oldest.status, status);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_cmd(OP_QUERY, 32'h0000_0005);
		send_cmd(OP_DELETE, 32'h0000_0005);
		send_cmd(OP_INSERT, 32'h8000_0000);
		send_cmd(OP_INSERT, 32'h7FFF_FFFF);
		send_cmd(OP_INSERT, 32'h0000_0000);
		send_cmd(OP_INSERT, 32'hFFFF_FFFF);
		send_cmd(OP_INSERT, 32'h0000_0000);
		send_cmd(OP_QUERY, 32'h7FFF_FFFF);
		send_cmd(OP_QUERY, 32'h7FFF_FFFE);
		// middle entry goes, later ones shift down
		send_cmd(OP_DELETE, 32'h7FFF_FFFF);
		send_cmd(OP_QUERY, 32'h0000_0000);
		send_cmd(OP_QUERY, 32'hFFFF_FFFF);
		send_cmd(OP_QUERY, 32'h7FFF_FFFF);
		send_cmd(OP_DELETE, 32'h0000_3039);
		send_cmd(OP_SPARE, 32'h0000_0000);
		send_cmd(OP_SPARE, 32'h1234_5678);
		send_cmd(OP_DELETE, 32'h8000_0000);
		send_cmd(OP_DELETE, 32'hFFFF_FFFF);
		send_cmd(OP_DELETE, 32'h0000_0000);
		send_cmd(OP_INSERT, 32'h5555_5555);
		send_cmd(OP_INSERT, 32'hAAAA_AAAA);
		send_cmd(OP_DELETE, 32'hAAAA_AAAA);
		send_cmd(OP_DELETE, 32'h5555_5555);
		send_cmd(OP_QUERY, 32'h5555_5555);
	endtask

	// fill up, then hit the full set with present and absent keys
	task automatic test_fill_to_full();
		int guard;
		guard = 0;
		while (held_count < SLOTS && guard < 2000) begin
			paced_send(pick_op(75, 10), pick_key());
			guard++;
		end
		repeat (120) paced_send(pick_op(70, 5), pick_key());
	endtask

	task automatic test_empty_out();
		int guard;
		guard = 0;
		while (held_count > 0 && guard < 2000) begin
			paced_send(pick_op(10, 75), pick_key());
			guard++;
		end
		repeat (40) paced_send(pick_op(30, 40), pick_key());
	endtask

	task automatic test_mixed();
		int ins;
		for (int seg = 0; seg < 11; seg++) begin
			ins = (seg % 3 == 0) ? 65 : (seg % 3 == 1) ? 45 : 30;
			repeat (100) paced_send(pick_op(ins, 35), pick_key());
		end
	endtask

	task automatic test_back_to_back();
		repeat (250) send_cmd(pick_op(45, 35), pick_key());
	endtask

	initial begin
		start = 1'b0;
		operation = OP_INSERT;
		key = '0;
		arst_n = 1'b0;
		held_count = 0;
		errors = 0;
		n_replies = 0;
		n_rejects = 0;
		n_removed = 0;
		n_full_seen = 0;
		n_empty_seen = 0;
		gaps_on = 1'b1;
		for (int i = 0; i < POOL; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		wait_quiet();
		test_fill_to_full();
		wait_quiet();
		test_empty_out();
		wait_quiet();
		test_mixed();
		wait_quiet();
		gaps_on = 1'b0;
		test_back_to_back();
		wait_quiet();

		$display("covered %0d transactions: %0d inserts refused on a full set, %0d keys removed,",
			n_replies, n_rejects, n_removed);
		$display("%0d replies with the set full and %0d with it empty", n_full_seen, n_empty_seen);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ set_membership_table.f @@
+incdir+hw/rtl
hw/rtl/sms_pkg.sv
hw/rtl/sms_cell.sv
hw/rtl/sms_prefix.sv
hw/rtl/set_membership_table.sv
hw/rtl/sms_chk.sv
test/testbench.sv
